@@ src/ed2k_frame_gate_top_defines.svh @@
// ----------------------------------------------------------------------------
// ed2k frame gate assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ED2K_FRAME_GATE_TOP_DEFINES_SVH
`define ED2K_FRAME_GATE_TOP_DEFINES_SVH

// Same-cycle implication.
`define ED2K_FG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ED2K_FG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ed2k_fg_pkg.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate package
// Types, codes and opcode tables shared by the frame gate modules.
// ----------------------------------------------------------------------------
package ed2k_fg_pkg;

  localparam int HEADER_BYTES = 6;
  localparam int HDR_POS_W    = 3;
  localparam int PADDR_W      = 4;

  localparam logic [1:0] REG_PROTO_BASE  = 2'd0;
  localparam logic [1:0] REG_PROTO_EXT   = 2'd1;
  localparam logic [1:0] REG_PROTO_PACK  = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd3;

  localparam logic [7:0]  RST_PROTO_BASE  = 8'hE3;
  localparam logic [7:0]  RST_PROTO_EXT   = 8'hC5;
  localparam logic [7:0]  RST_PROTO_PACK  = 8'hD4;
  localparam logic [31:0] RST_MAX_PAYLOAD = 32'd1048576;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC     = 2'd1,
    ST_MALFORMED = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    CLS_HELLO         = 4'd0,
    CLS_IP_REQ        = 4'd1,
    CLS_IP_ANS        = 4'd2,
    CLS_SRC_EXCH      = 4'd3,
    CLS_CALLBACK      = 4'd4,
    CLS_BUDDY         = 4'd5,
    CLS_ENDPOINT      = 4'd6,
    CLS_CONTENT       = 4'd7,
    CLS_SAFE          = 4'd8,
    CLS_UNKNOWN_CTRL  = 4'd9,
    CLS_PACKED        = 4'd10,
    CLS_UNKNOWN_PROTO = 4'd11
  } class_t;

  typedef enum logic [2:0] {
    DISP_PASS    = 3'd0,
    DISP_REWRITE = 3'd1,
    DISP_HINTS   = 3'd2,
    DISP_DROP    = 3'd3,
    DISP_REJECT  = 3'd4
  } disp_t;

  typedef struct packed {
    logic [7:0]  proto_base;
    logic [7:0]  proto_ext;
    logic [7:0]  proto_packed;
    logic [31:0] max_payload;
  } cfg_t;

  typedef struct packed {
    logic        header_done;
    logic        dir;
    logic [7:0]  proto;
    logic [7:0]  opcode;
    logic [31:0] length;
    logic [31:0] count;
  } snap_t;

  function automatic logic is_safe_base(input logic [7:0] op);
    logic hit;
    case (op) inside
      8'h47, 8'h48, 8'h49, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52,
      8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5b, 8'h5c: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_safe_ext(input logic [7:0] op);
    logic hit;
    case (op) inside
      8'h01, 8'h02, 8'h60, 8'h61, 8'h81, 8'h83, 8'h85, 8'h86, 8'h87,
      8'h90, 8'h91, 8'h92, 8'h93, 8'h9b, 8'h9c, 8'h9d, 8'h9e, 8'ha3,
      8'ha4, 8'ha5, 8'ha6, 8'ha9, 8'hb0, 8'hb1, 8'hb2: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_callback_ext(input logic [7:0] op);
    logic hit;
    case (op) inside
      8'h94, 8'h95, 8'h96, 8'h99, 8'h9a, 8'ha7, 8'ha8, 8'he1, 8'he2: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // The packed protocol wins over the other protocol matches.
  function automatic class_t classify(input logic [7:0] p, input logic [7:0] op,
                                      input cfg_t cfg);
    logic   b;
    logic   x;
    class_t c;
    b = (p == cfg.proto_base);
    x = (p == cfg.proto_ext);
    if (p == cfg.proto_packed) begin
      c = CLS_PACKED;
    end else if (!b && !x) begin
      c = CLS_UNKNOWN_PROTO;
    end else if (b && (op == 8'h01 || op == 8'h4c)) begin
      c = CLS_HELLO;
    end else if (x && op == 8'h97) begin
      c = CLS_IP_REQ;
    end else if (x && (op == 8'h98 || op == 8'hb3)) begin
      c = CLS_IP_ANS;
    end else if (x && (op == 8'h82 || op == 8'h84)) begin
      c = CLS_SRC_EXCH;
    end else if ((b && (op == 8'h1c || op == 8'h35 || op == 8'h36)) ||
                 (x && is_callback_ext(op))) begin
      c = CLS_CALLBACK;
    end else if (x && (op == 8'h9f || op == 8'ha0)) begin
      c = CLS_BUDDY;
    end else if (b && (op == 8'h4b || op == 8'h4d || op == 8'h60 || op == 8'hfe)) begin
      c = CLS_ENDPOINT;
    end else if ((b && op == 8'h46) ||
                 (x && (op == 8'h40 || op == 8'ha1 || op == 8'ha2))) begin
      c = CLS_CONTENT;
    end else if (b) begin
      c = is_safe_base(op) ? CLS_SAFE : CLS_UNKNOWN_CTRL;
    end else begin
      c = is_safe_ext(op) ? CLS_SAFE : CLS_UNKNOWN_CTRL;
    end
    return c;
  endfunction

  function automatic disp_t policy(input logic dir, input class_t c);
    disp_t d;
    case (c) inside
      CLS_HELLO, CLS_IP_ANS:                        d = dir ? DISP_PASS : DISP_REWRITE;
      CLS_SRC_EXCH:                                 d = dir ? DISP_HINTS : DISP_DROP;
      CLS_CALLBACK, CLS_BUDDY, CLS_ENDPOINT:        d = DISP_DROP;
      CLS_UNKNOWN_CTRL, CLS_PACKED, CLS_UNKNOWN_PROTO: d = DISP_REJECT;
      default:                                      d = DISP_PASS;
    endcase
    return d;
  endfunction

endpackage

@@ src/ed2k_fg_if.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate channel interfaces
// Valid/ready channels for frame bytes in and frame results out.
// ----------------------------------------------------------------------------
interface ed2k_fg_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       direction;

  modport source (output valid, data_byte, last_byte, direction, input ready);
  modport sink (input valid, data_byte, last_byte, direction, output ready);
endinterface

interface ed2k_fg_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  protocol_byte;
  logic [7:0]  opcode_byte;
  logic [31:0] body_len;
  logic [3:0]  frame_class;
  logic [2:0]  disposition;

  modport source (output valid, status, protocol_byte, opcode_byte, body_len,
                  frame_class, disposition, input ready);
  modport sink (input valid, status, protocol_byte, opcode_byte, body_len,
                frame_class, disposition, output ready);
endinterface

@@ src/ed2k_frame_gate_top.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate top level
// While the result side does not stall, it takes one frame byte every cycle and
// one frame can end on every cycle. A frame's last byte loads the snapshot
// register, whose word then moves into the output register as the result word.
// Reset clears the frame state and both valid flags and loads the registers
// with their default protocol bytes and payload limit.
// ----------------------------------------------------------------------------
module ed2k_frame_gate_top (
  input  logic                             clk,
  input  logic                             rst,
  ed2k_fg_byte_if.sink                     frame_in,
  ed2k_fg_result_if.source                 result_out,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ed2k_fg_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  ed2k_fg_pkg::cfg_t  cfg;
  ed2k_fg_pkg::snap_t snap;
  logic               snap_valid;
  logic               snap_ready;

  ed2k_fg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ed2k_fg_track u_track (
    .clk        (clk),
    .rst        (rst),
    .frame_in   (frame_in),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  ed2k_fg_result u_result (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready),
    .result_out (result_out)
  );

endmodule

@@ src/ed2k_fg_regs.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate configuration registers
// APB register file holding the protocol bytes and the payload limit.
// ----------------------------------------------------------------------------
module ed2k_fg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ed2k_fg_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output ed2k_fg_pkg::cfg_t                cfg
);

  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.proto_base   <= ed2k_fg_pkg::RST_PROTO_BASE;
      cfg.proto_ext    <= ed2k_fg_pkg::RST_PROTO_EXT;
      cfg.proto_packed <= ed2k_fg_pkg::RST_PROTO_PACK;
      cfg.max_payload  <= ed2k_fg_pkg::RST_MAX_PAYLOAD;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index)
        ed2k_fg_pkg::REG_PROTO_BASE:  cfg.proto_base   <= pwdata[7:0];
        ed2k_fg_pkg::REG_PROTO_EXT:   cfg.proto_ext    <= pwdata[7:0];
        ed2k_fg_pkg::REG_PROTO_PACK:  cfg.proto_packed <= pwdata[7:0];
        ed2k_fg_pkg::REG_MAX_PAYLOAD: cfg.max_payload  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      ed2k_fg_pkg::REG_PROTO_BASE:  prdata = {24'd0, cfg.proto_base};
      ed2k_fg_pkg::REG_PROTO_EXT:   prdata = {24'd0, cfg.proto_ext};
      ed2k_fg_pkg::REG_PROTO_PACK:  prdata = {24'd0, cfg.proto_packed};
      ed2k_fg_pkg::REG_MAX_PAYLOAD: prdata = cfg.max_payload;
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

@@ src/ed2k_fg_track.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate frame tracker
// Captures the header, counts payload bytes and snapshots the frame at its end.
// ----------------------------------------------------------------------------
module ed2k_fg_track (
  input  logic                clk,
  input  logic                rst,
  ed2k_fg_byte_if.sink        frame_in,
  output logic                snap_valid,
  output ed2k_fg_pkg::snap_t  snap,
  input  logic                snap_ready
);

  localparam int PW = ed2k_fg_pkg::HDR_POS_W;
  localparam logic [PW-1:0] HDR_END = PW'(ed2k_fg_pkg::HEADER_BYTES);

  logic [PW-1:0] header_pos, header_pos_next;
  logic [7:0]    proto_reg, proto_reg_next;
  logic [7:0]    opcode_reg, opcode_reg_next;
  logic [31:0]   length_reg, length_reg_next;
  logic [31:0]   payload_count, payload_count_next;
  logic          dir_reg, dir_reg_next;
  logic [31:0]   limit;
  logic          accept;

  assign frame_in.ready = !snap_valid || snap_ready;
  assign accept         = frame_in.valid && frame_in.ready;

  always_comb begin
    header_pos_next    = header_pos;
    proto_reg_next     = proto_reg;
    opcode_reg_next    = opcode_reg;
    length_reg_next    = length_reg;
    payload_count_next = payload_count;
    dir_reg_next       = dir_reg;
    limit              = (length_reg == 32'd0) ? 32'd1 : length_reg;
    if (header_pos < HDR_END) begin
      header_pos_next = header_pos + PW'(1);
      case (header_pos)
        PW'(0): begin
          proto_reg_next = frame_in.data_byte;
          dir_reg_next   = frame_in.direction;
        end
        PW'(1): length_reg_next[7:0]   = frame_in.data_byte;
        PW'(2): length_reg_next[15:8]  = frame_in.data_byte;
        PW'(3): length_reg_next[23:16] = frame_in.data_byte;
        PW'(4): length_reg_next[31:24] = frame_in.data_byte;
        default: opcode_reg_next = frame_in.data_byte;
      endcase
    end else if (payload_count < limit) begin
      payload_count_next = payload_count + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_pos    <= '0;
      proto_reg     <= '0;
      opcode_reg    <= '0;
      length_reg    <= '0;
      payload_count <= '0;
      dir_reg       <= 1'b0;
    end else if (accept) begin
      if (frame_in.last_byte) begin
        header_pos    <= '0;
        proto_reg     <= '0;
        opcode_reg    <= '0;
        length_reg    <= '0;
        payload_count <= '0;
        dir_reg       <= 1'b0;
      end else begin
        header_pos    <= header_pos_next;
        proto_reg     <= proto_reg_next;
        opcode_reg    <= opcode_reg_next;
        length_reg    <= length_reg_next;
        payload_count <= payload_count_next;
        dir_reg       <= dir_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && frame_in.last_byte) begin
      snap_valid <= 1'b1;
    end else if (snap_ready) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_in.last_byte) begin
      snap.header_done <= (header_pos_next == HDR_END);
      snap.dir         <= dir_reg_next;
      snap.proto       <= proto_reg_next;
      snap.opcode      <= opcode_reg_next;
      snap.length      <= length_reg_next;
      snap.count       <= payload_count_next;
    end
  end

endmodule

@@ src/ed2k_fg_result.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate result stage
// Works out status, class and disposition and holds them in the output register.
// ----------------------------------------------------------------------------
module ed2k_fg_result (
  input  logic                clk,
  input  logic                rst,
  input  ed2k_fg_pkg::cfg_t   cfg,
  input  logic                snap_valid,
  input  ed2k_fg_pkg::snap_t  snap,
  output logic                snap_ready,
  ed2k_fg_result_if.source    result_out
);

  ed2k_fg_pkg::status_t status_next;
  ed2k_fg_pkg::class_t  class_next;
  ed2k_fg_pkg::disp_t   disp_next;
  logic [31:0]          size_next;
  logic [31:0]          plen;

  assign snap_ready = !result_out.valid || result_out.ready;
  assign plen       = snap.length - 32'd1;

  always_comb begin
    status_next = ed2k_fg_pkg::ST_TRUNC;
    class_next  = ed2k_fg_pkg::CLS_HELLO;
    disp_next   = ed2k_fg_pkg::DISP_PASS;
    size_next   = 32'd0;
    if (snap.header_done) begin
      class_next = ed2k_fg_pkg::classify(snap.proto, snap.opcode, cfg);
      disp_next  = ed2k_fg_pkg::policy(snap.dir, class_next);
      if (snap.length == 32'd0) begin
        status_next = ed2k_fg_pkg::ST_MALFORMED;
      end else if (plen > cfg.max_payload) begin
        status_next = ed2k_fg_pkg::ST_TOO_LARGE;
      end else if (snap.count < plen) begin
        status_next = ed2k_fg_pkg::ST_TRUNC;
      end else if (snap.count > plen) begin
        status_next = ed2k_fg_pkg::ST_MALFORMED;
      end else begin
        status_next = ed2k_fg_pkg::ST_OK;
        size_next   = plen;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (snap_ready) begin
      result_out.valid <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      result_out.status        <= status_next;
      result_out.protocol_byte <= snap.proto;
      result_out.opcode_byte   <= snap.opcode;
      result_out.body_len      <= size_next;
      result_out.frame_class   <= class_next;
      result_out.disposition   <= disp_next;
    end
  end

endmodule

@@ src/ed2k_fg_checker.sv @@
// ----------------------------------------------------------------------------
// ed2k frame gate checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "ed2k_frame_gate_top_defines.svh"

module ed2k_fg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] body_len,
  input logic [3:0]  frame_class,
  input logic [2:0]  disposition
);

  `ED2K_FG_ASSERT_NEXT(a_hold_on_stall, out_valid && !out_ready, out_valid && $stable(status) && $stable(body_len) && $stable(frame_class) && $stable(disposition), "result word changed while stalled")

  `ED2K_FG_ASSERT_NOW(a_size_only_ok, out_valid && status != ed2k_fg_pkg::ST_OK, body_len == 32'd0, "payload size given for a bad frame")

  `ED2K_FG_ASSERT_NOW(a_reject_class, out_valid && (frame_class == ed2k_fg_pkg::CLS_UNKNOWN_CTRL || frame_class == ed2k_fg_pkg::CLS_PACKED || frame_class == ed2k_fg_pkg::CLS_UNKNOWN_PROTO), disposition == ed2k_fg_pkg::DISP_REJECT, "unknown or packed frame not rejected")

  `ED2K_FG_ASSERT_NOW(a_hints_class, out_valid && disposition == ed2k_fg_pkg::DISP_HINTS, frame_class == ed2k_fg_pkg::CLS_SRC_EXCH, "hint conversion outside source exchange")

endmodule

bind ed2k_frame_gate_top ed2k_fg_checker u_ed2k_fg_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .status       (result_out.status),
  .body_len     (result_out.body_len),
  .frame_class  (result_out.frame_class),
  .disposition  (result_out.disposition)
);
